// File: rtl/core/ngfp_pkg.sv
package ngfp_pkg;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_ONE    = 8'h31;
  localparam logic [7:0] CHAR_N      = 8'h4E;
  localparam logic [7:0] CHAR_E      = 8'h45;

  localparam logic [23:0] HDR_GSA = 24'h475341;
  localparam logic [23:0] HDR_GLL = 24'h474C4C;

  localparam logic [3:0] FLD_FIX = 4'd2;
  localparam logic [3:0] FLD_LAT = 4'd1;
  localparam logic [3:0] FLD_NS  = 4'd2;
  localparam logic [3:0] FLD_LON = 4'd3;
  localparam logic [3:0] FLD_EW  = 4'd4;
  localparam logic [3:0] FLD_UTC = 4'd5;

  localparam logic [3:0] CNT_MAX = 4'd15;

  typedef struct packed {
    logic [13:0] utc_seconds_e2;
    logic [6:0]  utc_minutes;
    logic [6:0]  utc_hours;
    logic        lon_west;
    logic [23:0] lon_minutes_e5;
    logic [9:0]  lon_degrees;
    logic        lat_south;
    logic [23:0] lat_minutes_e5;
    logic [6:0]  lat_degrees;
    logic [7:0]  fix_code;
  } ngfp_rec_t;

  // per-byte decode handed from framer to record
  typedef struct packed {
    logic       emit;
    logic       emit_gll;
    logic       body_gsa;
    logic       body_gll;
    logic [3:0] field;
    logic [3:0] offset;
  } ngfp_ctl_t;

  function automatic logic [3:0] digit_of(input logic [7:0] c);
    logic [7:0] t;
    t = c - CHAR_ZERO;
    return (c >= CHAR_ZERO && c <= CHAR_NINE) ? t[3:0] : 4'd0;
  endfunction

  // ddmm.mmmmm
  function automatic logic [19:0] lat_weight(input logic [3:0] off);
    logic [19:0] w;
    case (off)
      4'd0:    w = 20'd10;
      4'd1:    w = 20'd1;
      4'd2:    w = 20'd1000000;
      4'd3:    w = 20'd100000;
      4'd5:    w = 20'd10000;
      4'd6:    w = 20'd1000;
      4'd7:    w = 20'd100;
      4'd8:    w = 20'd10;
      4'd9:    w = 20'd1;
      default: w = 20'd0;
    endcase
    return w;
  endfunction

  // dddmm.mmmmm
  function automatic logic [19:0] lon_weight(input logic [3:0] off);
    logic [19:0] w;
    case (off)
      4'd0:    w = 20'd100;
      4'd1:    w = 20'd10;
      4'd2:    w = 20'd1;
      4'd3:    w = 20'd1000000;
      4'd4:    w = 20'd100000;
      4'd6:    w = 20'd10000;
      4'd7:    w = 20'd1000;
      4'd8:    w = 20'd100;
      4'd9:    w = 20'd10;
      4'd10:   w = 20'd1;
      default: w = 20'd0;
    endcase
    return w;
  endfunction

  // hhmmss.ss
  function automatic logic [9:0] time_weight(input logic [3:0] off);
    logic [9:0] w;
    case (off)
      4'd0:    w = 10'd10;
      4'd1:    w = 10'd1;
      4'd2:    w = 10'd10;
      4'd3:    w = 10'd1;
      4'd4:    w = 10'd1000;
      4'd5:    w = 10'd100;
      4'd7:    w = 10'd10;
      4'd8:    w = 10'd1;
      default: w = 10'd0;
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/nmea_gll_gsa_field_parser.sv
// channel  dir  tdata                         tuser
// s        in   [7:0] in_byte                 -
// m        out  [102:0] record, bit 103 zero  [0] sentence_kind
//
// One byte per cycle while no result is stalled; a byte is held in the input register
// and updates the sentence state and kept record when it steps out of that register.
// A result is registered in the output register when its line feed steps out of the input register.
// Reset clears the sentence state and the kept record to zero.
// A stalled result holds only a line feed in the input register; other bytes
// keep flowing, and the input waits only behind such a line feed.
module nmea_gll_gsa_field_parser import ngfp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  input  logic [7:0]   s_tdata_i,   // [7:0] in_byte
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  // [7:0] fix_code, [14:8] lat_degrees, [38:15] lat_minutes_e5, [39] lat_south,
  // [49:40] lon_degrees, [73:50] lon_minutes_e5, [74] lon_west,
  // [81:75] utc_hours, [88:82] utc_minutes, [102:89] utc_seconds_e2
  output logic [103:0] m_tdata_o,
  output logic         m_tuser_o    // [0] sentence_kind
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       step;
  ngfp_ctl_t  ctl;
  ngfp_rec_t  rec;
  logic       out_vld_q;
  ngfp_rec_t  out_rec_q;
  logic       out_kind_q;

  assign step       = in_vld_q && (!ctl.emit || !out_vld_q || m_tready_i);
  assign s_tready_o = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_tready_o) begin
      in_vld_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      in_byte_q <= s_tdata_i;
    end
  end

  ngfp_framer u_framer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .ctl_o  (ctl)
  );

  ngfp_record u_record (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .ctl_i  (ctl),
    .rec_o  (rec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step && ctl.emit) begin
      out_vld_q <= 1'b1;
    end else if (m_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && ctl.emit) begin
      out_rec_q  <= rec;
      out_kind_q <= ctl.emit_gll;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = {1'b0, out_rec_q};
  assign m_tuser_o  = out_kind_q;

endmodule

// File: rtl/core/ngfp_framer.sv
module ngfp_framer import ngfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output ngfp_ctl_t  ctl_o
);

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_GSA,
    KIND_GLL
  } kind_e;

  logic        in_sent_q, in_sent_d;
  logic [2:0]  pos_q, pos_d;
  logic [23:0] hdr_q, hdr_d;
  kind_e       kind_q, kind_d;
  logic [3:0]  fld_q, fld_d;
  logic [3:0]  off_q, off_d;

  always_comb begin
    in_sent_d = in_sent_q;
    pos_d     = pos_q;
    hdr_d     = hdr_q;
    kind_d    = kind_q;
    fld_d     = fld_q;
    off_d     = off_q;
    ctl_o          = '0;
    ctl_o.field    = fld_q;
    ctl_o.offset   = off_q;
    if (byte_i == CHAR_DOLLAR) begin
      in_sent_d = 1'b1;
      pos_d     = 3'd1;
      hdr_d     = '0;
      kind_d    = KIND_NONE;
      fld_d     = '0;
      off_d     = '0;
    end else if (in_sent_q) begin
      if (byte_i == CHAR_LF) begin
        in_sent_d = 1'b0;
        if (kind_q != KIND_NONE) begin
          ctl_o.emit     = 1'b1;
          ctl_o.emit_gll = (kind_q == KIND_GLL);
          kind_d         = KIND_NONE;
        end
      end else if (pos_q < 3'd6) begin
        if (pos_q >= 3'd3) begin
          hdr_d = {hdr_q[15:0], byte_i};
        end
        pos_d = pos_q + 3'd1;
        if (pos_q == 3'd5) begin
          if (hdr_d == HDR_GSA) begin
            kind_d = KIND_GSA;
          end else if (hdr_d == HDR_GLL) begin
            kind_d = KIND_GLL;
          end else begin
            kind_d = KIND_NONE;
          end
        end
      end else if (byte_i == CHAR_COMMA) begin
        if (fld_q != CNT_MAX) begin
          fld_d = fld_q + 4'd1;
        end
        off_d = '0;
      end else begin
        ctl_o.body_gsa = (kind_q == KIND_GSA);
        ctl_o.body_gll = (kind_q == KIND_GLL);
        if (off_q != CNT_MAX) begin
          off_d = off_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sent_q <= 1'b0;
      pos_q     <= '0;
      hdr_q     <= '0;
      kind_q    <= KIND_NONE;
      fld_q     <= '0;
      off_q     <= '0;
    end else if (step_i) begin
      in_sent_q <= in_sent_d;
      pos_q     <= pos_d;
      hdr_q     <= hdr_d;
      kind_q    <= kind_d;
      fld_q     <= fld_d;
      off_q     <= off_d;
    end
  end

endmodule

// File: rtl/core/ngfp_record.sv
module ngfp_record import ngfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  ngfp_ctl_t  ctl_i,
  output ngfp_rec_t  rec_o
);

  ngfp_rec_t   rec_q, rec_d;
  logic [3:0]  dig;
  logic [23:0] lat_prod;
  logic [23:0] lon_prod;
  logic [13:0] utc_prod;
  logic        first;
  logic [7:0]  fix_val;

  assign dig      = digit_of(byte_i);
  assign lat_prod = {20'd0, dig} * lat_weight(ctl_i.offset);
  assign lon_prod = {20'd0, dig} * lon_weight(ctl_i.offset);
  assign utc_prod = {10'd0, dig} * time_weight(ctl_i.offset);
  assign first    = (ctl_i.offset == 4'd0);
  assign fix_val  = byte_i - CHAR_ONE;

  always_comb begin
    rec_d = rec_q;
    if (ctl_i.body_gsa && ctl_i.field == FLD_FIX && first) begin
      rec_d.fix_code = fix_val;
    end
    if (ctl_i.body_gll) begin
      case (ctl_i.field)
        FLD_LAT: begin
          if (first) begin
            rec_d.lat_degrees    = '0;
            rec_d.lat_minutes_e5 = '0;
          end
          if (ctl_i.offset < 4'd2) begin
            rec_d.lat_degrees = rec_d.lat_degrees + lat_prod[6:0];
          end else if (ctl_i.offset < 4'd10) begin
            rec_d.lat_minutes_e5 = rec_d.lat_minutes_e5 + lat_prod;
          end
        end
        FLD_NS: begin
          if (first) begin
            rec_d.lat_south = (byte_i != CHAR_N);
          end
        end
        FLD_LON: begin
          if (first) begin
            rec_d.lon_degrees    = '0;
            rec_d.lon_minutes_e5 = '0;
          end
          if (ctl_i.offset < 4'd3) begin
            rec_d.lon_degrees = rec_d.lon_degrees + lon_prod[9:0];
          end else if (ctl_i.offset < 4'd11) begin
            rec_d.lon_minutes_e5 = rec_d.lon_minutes_e5 + lon_prod;
          end
        end
        FLD_EW: begin
          if (first) begin
            rec_d.lon_west = (byte_i != CHAR_E);
          end
        end
        FLD_UTC: begin
          if (first) begin
            rec_d.utc_hours      = '0;
            rec_d.utc_minutes    = '0;
            rec_d.utc_seconds_e2 = '0;
          end
          if (ctl_i.offset < 4'd2) begin
            rec_d.utc_hours = rec_d.utc_hours + utc_prod[6:0];
          end else if (ctl_i.offset < 4'd4) begin
            rec_d.utc_minutes = rec_d.utc_minutes + utc_prod[6:0];
          end else if (ctl_i.offset < 4'd9) begin
            rec_d.utc_seconds_e2 = rec_d.utc_seconds_e2 + utc_prod;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else if (step_i) begin
      rec_q <= rec_d;
    end
  end

  assign rec_o = rec_q;

endmodule

// File: rtl/core/ngfp_checker.sv
module ngfp_checker import ngfp_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_tvalid_i,
  input logic         s_tready_o,
  input logic [7:0]   s_tdata_i,
  input logic         m_tvalid_o,
  input logic         m_tready_i,
  input logic [103:0] m_tdata_o,
  input logic         m_tuser_o
);

  a_m_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o)
    else $error("result dropped while stalled");

  // input side can only back up behind a stalled result
  a_s_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> m_tvalid_o && !m_tready_i)
    else $error("input request refused without output stall");

  // a new result rises only after its line feed request has passed the input register
  a_emit_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_o) |-> $past(s_tvalid_i && s_tready_o && s_tdata_i == CHAR_LF, 2))
    else $error("result without a line feed request");

endmodule

bind nmea_gll_gsa_field_parser ngfp_checker u_ngfp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .s_tdata_i  (s_tdata_i),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o),
  .m_tuser_o  (m_tuser_o)
);
